FILE: sv/tcw_pkg.sv
// tcw_pkg: screen geometry, character codes, operation codes and shared types
// for the text console writer; no dependencies, imported by all but tcw_ram

package tcw_pkg;

   // screen geometry
   localparam int COLUMNS  = 80;
   localparam int ROWS     = 25;
   localparam int TAB_STOP = 4;
   localparam int CELLS    = COLUMNS * ROWS;

   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);

   // fixed port widths
   localparam int OP_W       = 2;
   localparam int CHAR_W     = 8;
   localparam int INDEX_W    = 11;
   localparam int OUT_COL_W  = 7;
   localparam int OUT_ROW_W  = 5;
   localparam int OUT_POS_W  = 11;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // character codes
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h00;

   localparam logic [CHAR_W-1:0] RESET_COLOR = 8'h07;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_WRITE,
      ST_SCROLL_COPY,
      ST_SCROLL_FILL,
      ST_CLEAR,
      ST_FINISH
   } state_type;

   // one write port and one read port shared by both stores
   typedef struct packed {
      logic              char_we;
      logic              color_we;
      logic [ADDR_W-1:0] waddr;
      logic [CHAR_W-1:0] char_wdata;
      logic [CHAR_W-1:0] color_wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_cmd_type;

   typedef struct packed {
      logic [OUT_COL_W-1:0] cursor_col;
      logic [OUT_ROW_W-1:0] cursor_row;
      logic [OUT_POS_W-1:0] cursor_position;
      logic [CHAR_W-1:0]    cell_char;
      logic [CHAR_W-1:0]    cell_color;
      logic                 scrolled;
   } rsp_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

endpackage

FILE: sv/tcw_ram.sv
// tcw_ram: simple dual-port synchronous memory, one write and one registered read
// per cycle; generic, no package dependency

module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/tcw_sequencer.sv
// tcw_sequencer: cursor state and the control sequencer that drives the
// character and color memories; depends on tcw_pkg

module tcw_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tcw_pkg::OP_W-1:0]      req_operation,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::INDEX_W-1:0]   req_cell_index,
   input  logic [tcw_pkg::CHAR_W-1:0]    fill_color,
   input  logic [tcw_pkg::CHAR_W-1:0]    char_rdata,
   input  logic [tcw_pkg::CHAR_W-1:0]    color_rdata,
   output tcw_pkg::mem_cmd_type          mem_cmd,
   input  logic                          slot_free,
   output logic                          done,
   output tcw_pkg::rsp_type              result
);

   import tcw_pkg::*;

   state_type           state_ff, state_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [CHAR_W-1:0]   code_ff, code_in;
   logic                is_tab_ff, is_tab_in;
   logic                is_read_ff, is_read_in;
   logic                scrolled_ff, scrolled_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   wr_ff, wr_in;

   logic                accept;
   logic [COL_W:0]      col_inc;
   logic [ROW_W:0]      row_inc;
   logic                wrap;
   logic                row_over;
   logic [COL_W-1:0]    glyph_col;
   logic                glyph_scroll;
   logic                tab_more;
   logic                cnt_last;
   logic                copy_reading;
   logic                copy_last;
   logic                index_ok;
   logic [15:0]         index_ext;
   logic [ROW_W-1:0]    row_bumped;
   logic [15:0]         col_ext, row_ext, pos_ext;

   assign accept       = req_valid && (state_ff == ST_IDLE);
   assign col_inc      = {1'b0, col_ff} + (COL_W+1)'(1);
   assign row_inc      = {1'b0, row_ff} + (ROW_W+1)'(1);
   assign wrap         = col_inc >= (COL_W+1)'(COLUMNS);
   assign row_over     = row_inc >= (ROW_W+1)'(ROWS);
   assign row_bumped   = row_over ? ROW_W'(ROWS - 1) : row_inc[ROW_W-1:0];
   assign glyph_col    = wrap ? '0 : col_inc[COL_W-1:0];
   assign glyph_scroll = wrap && row_over;
   assign tab_more     = is_tab_ff && ((glyph_col % COL_W'(TAB_STOP)) != '0);
   assign cnt_last     = cnt_ff == CNT_W'(CELLS - 1);
   assign copy_reading = cnt_ff < CNT_W'(CELLS);
   assign copy_last    = pend_ff && (wr_ff == ADDR_W'(CELLS - COLUMNS - 1));
   assign index_ext    = 16'(req_cell_index);
   assign index_ok     = 32'(req_cell_index) < CELLS;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               priority if (req_operation == OP_PUT) begin
                  priority if (req_char_code == CH_NEWLINE) begin
                     state_in = row_over ? ST_SCROLL_COPY : ST_FINISH;
                  end else if (req_char_code == CH_RETURN) begin
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_WRITE;
                  end
               end else if (req_operation == OP_CLEAR) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_WRITE: begin
            priority if (glyph_scroll) state_in = ST_SCROLL_COPY;
            else if (tab_more)         state_in = ST_WRITE;
            else                       state_in = ST_FINISH;
         end
         ST_SCROLL_COPY: begin
            if (copy_last) state_in = ST_SCROLL_FILL;
         end
         ST_SCROLL_FILL: begin
            if (cnt_last) state_in = ST_FINISH;
         end
         ST_CLEAR: begin
            if (cnt_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // cursor, counters and captured request
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      code_in     = code_ff;
      is_tab_in   = is_tab_ff;
      is_read_in  = is_read_ff;
      scrolled_in = scrolled_ff;
      cnt_in      = cnt_ff;
      pend_in     = 1'b0;
      wr_in       = wr_ff;
      unique case (state_ff)
         ST_INIT, ST_CLEAR, ST_SCROLL_FILL: begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               code_in     = req_char_code;
               is_tab_in   = req_char_code == CH_TAB;
               is_read_in  = (req_operation == OP_READ) && index_ok;
               scrolled_in = 1'b0;
               cnt_in      = CNT_W'(COLUMNS);
               if (req_operation == OP_PUT) begin
                  if (req_char_code == CH_NEWLINE) begin
                     col_in      = '0;
                     row_in      = row_bumped;
                     scrolled_in = row_over;
                  end else if (req_char_code == CH_RETURN) begin
                     col_in = '0;
                  end
               end else if (req_operation == OP_CLEAR) begin
                  col_in = '0;
                  row_in = '0;
                  cnt_in = '0;
               end
            end
         end
         ST_WRITE: begin
            col_in      = glyph_col;
            row_in      = wrap ? row_bumped : row_ff;
            scrolled_in = scrolled_ff | glyph_scroll;
            cnt_in      = CNT_W'(COLUMNS);
         end
         ST_SCROLL_COPY: begin
            // reads run one row ahead of writes, so no entry is read and written at once
            pend_in = copy_reading;
            wr_in   = ADDR_W'(cnt_ff - CNT_W'(COLUMNS));
            if (copy_reading) cnt_in = cnt_ff + CNT_W'(1);
            if (copy_last)    cnt_in = CNT_W'(CELLS - COLUMNS);
         end
         ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // memory commands and handshake
   always_comb begin
      mem_cmd             = '0;
      mem_cmd.raddr       = index_ext[ADDR_W-1:0];
      mem_cmd.waddr       = cnt_ff[ADDR_W-1:0];
      mem_cmd.char_wdata  = CH_BLANK;
      mem_cmd.color_wdata = fill_color;
      req_ready           = 1'b0;
      done                = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            mem_cmd.char_we     = 1'b1;
            mem_cmd.color_we    = 1'b1;
            mem_cmd.color_wdata = RESET_COLOR;
         end
         ST_CLEAR, ST_SCROLL_FILL: begin
            mem_cmd.char_we  = 1'b1;
            mem_cmd.color_we = 1'b1;
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            mem_cmd.re = accept && (req_operation == OP_READ);
         end
         ST_WRITE: begin
            mem_cmd.char_we    = 1'b1;
            mem_cmd.waddr      = cell_addr(row_ff, col_ff);
            mem_cmd.char_wdata = is_tab_ff ? CH_SPACE : code_ff;
         end
         ST_SCROLL_COPY: begin
            mem_cmd.re          = copy_reading;
            mem_cmd.raddr       = cnt_ff[ADDR_W-1:0];
            mem_cmd.char_we     = pend_ff;
            mem_cmd.color_we    = pend_ff;
            mem_cmd.waddr       = wr_ff;
            mem_cmd.char_wdata  = char_rdata;
            mem_cmd.color_wdata = color_rdata;
         end
         ST_FINISH: begin
            done = slot_free;
         end
         default: begin
         end
      endcase
   end

   assign col_ext = 16'(col_ff);
   assign row_ext = 16'(row_ff);
   assign pos_ext = 16'(cell_addr(row_ff, col_ff));

   always_comb begin
      result.cursor_col      = col_ext[OUT_COL_W-1:0];
      result.cursor_row      = row_ext[OUT_ROW_W-1:0];
      result.cursor_position = pos_ext[OUT_POS_W-1:0];
      result.cell_char       = is_read_ff ? char_rdata : CH_BLANK;
      result.cell_color      = is_read_ff ? color_rdata : '0;
      result.scrolled        = scrolled_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         col_ff   <= '0;
         row_ff   <= '0;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      is_tab_ff   <= is_tab_in;
      is_read_ff  <= is_read_in;
      scrolled_ff <= scrolled_in;
      wr_ff       <= wr_in;
   end

endmodule

FILE: sv/text_console_writer.sv
// text_console_writer: teletype-style text screen with character and color memories
// operations: a scroll sweeps the memories, copying every row up by one and then
//   filling the bottom row; a clear sweeps every cell
// requests: one at a time, req_ready is high only while the sequencer is idle
// reset: synchronous; after reset an init pass over all CELLS cells clears the memories
//   and req_ready stays low; csr writes are taken throughout
// depends on tcw_pkg, tcw_ram, tcw_sequencer

module text_console_writer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tcw_pkg::OP_W-1:0]      req_operation,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::INDEX_W-1:0]   req_cell_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tcw_pkg::OUT_COL_W-1:0] rsp_cursor_col,
   output logic [tcw_pkg::OUT_ROW_W-1:0] rsp_cursor_row,
   output logic [tcw_pkg::OUT_POS_W-1:0] rsp_cursor_position,
   output logic [tcw_pkg::CHAR_W-1:0]    rsp_cell_char,
   output logic [tcw_pkg::CHAR_W-1:0]    rsp_cell_color,
   output logic                          rsp_scrolled,
   input  logic                          csr_we,
   input  logic [tcw_pkg::CHAR_W-1:0]    csr_wdata
);

   import tcw_pkg::*;

   // fill color from csr writes, used on clear and on the row exposed by a scroll
   logic [CHAR_W-1:0] fill_color_ff, fill_color_in;

   // response holding register, lets the sequencer take the next request
   // while a finished response is still waiting
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   mem_cmd_type       mem_cmd;
   logic [CHAR_W-1:0] char_rdata;
   logic [CHAR_W-1:0] color_rdata;
   logic              slot_free;
   logic              done;
   rsp_type           result;

   // response slot is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   tcw_sequencer u_sequencer (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .fill_color     (fill_color_ff),
      .char_rdata     (char_rdata),
      .color_rdata    (color_rdata),
      .mem_cmd        (mem_cmd),
      .slot_free      (slot_free),
      .done           (done),
      .result         (result)
   );

   // character store, a put writes only this one
   tcw_ram #(.WIDTH(CHAR_W), .DEPTH(CELLS)) u_char_ram (
      .clock (clock),
      .we    (mem_cmd.char_we),
      .waddr (mem_cmd.waddr),
      .wdata (mem_cmd.char_wdata),
      .re    (mem_cmd.re),
      .raddr (mem_cmd.raddr),
      .rdata (char_rdata)
   );

   // color store, kept apart so a put leaves the cell's color alone
   tcw_ram #(.WIDTH(CHAR_W), .DEPTH(CELLS)) u_color_ram (
      .clock (clock),
      .we    (mem_cmd.color_we),
      .waddr (mem_cmd.waddr),
      .wdata (mem_cmd.color_wdata),
      .re    (mem_cmd.re),
      .raddr (mem_cmd.raddr),
      .rdata (color_rdata)
   );

   always_comb begin
      fill_color_in = csr_we ? csr_wdata : fill_color_ff;
      rsp_valid_in  = done || (rsp_valid_ff && !rsp_ready);
      rsp_in        = done ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_color_ff <= RESET_COLOR;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_color_ff <= fill_color_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_col      = rsp_ff.cursor_col;
   assign rsp_cursor_row      = rsp_ff.cursor_row;
   assign rsp_cursor_position = rsp_ff.cursor_position;
   assign rsp_cell_char       = rsp_ff.cell_char;
   assign rsp_cell_color      = rsp_ff.cell_color;
   assign rsp_scrolled        = rsp_ff.scrolled;

endmodule

FILE: dv/tb_text_console_writer.sv
// tb_text_console_writer: self-checking testbench for the teletype text console writer
// needs tcw_pkg and text_console_writer; a shadow screen predicts every response
// a queue-fed request driver and a response monitor run as clocked always blocks

module tb_text_console_writer;
   timeunit 1ns;
   timeprecision 1ps;

   import tcw_pkg::*;

   // run shape
   localparam int CLK_HALF        = 4;
   localparam int PHASES          = 6;
   localparam int REQS_PER_PHASE  = 195;
   localparam int TAIL_CYCLES     = 50;
   localparam int SETTLE_CYCLES   = 8;
   localparam int REPORT_LIMIT    = 10;
   localparam int unsigned LIMIT_CYCLES = 12_000_000;

   // opcode that the block leaves undecoded
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [CHAR_W-1:0]  code;
      logic [INDEX_W-1:0] index;
   } console_req_type;

   // dut inputs, all known from time zero
   logic                 clock               = 1'b0;
   logic                 reset               = 1'b1;
   logic                 req_valid           = 1'b0;
   logic                 req_ready;
   logic [OP_W-1:0]      req_operation       = OP_PUT;
   logic [CHAR_W-1:0]    req_char_code       = '0;
   logic [INDEX_W-1:0]   req_cell_index      = '0;
   logic                 rsp_valid;
   logic                 rsp_ready           = 1'b0;
   logic [OUT_COL_W-1:0] rsp_cursor_col;
   logic [OUT_ROW_W-1:0] rsp_cursor_row;
   logic [OUT_POS_W-1:0] rsp_cursor_position;
   logic [CHAR_W-1:0]    rsp_cell_char;
   logic [CHAR_W-1:0]    rsp_cell_color;
   logic                 rsp_scrolled;
   logic                 csr_we              = 1'b0;
   logic [CHAR_W-1:0]    csr_wdata           = '0;

   // request backlog, responses still owed, bookkeeping
   console_req_type req_pending_q[$];
   rsp_type         rsp_expected_q[$];
   int           fail_count   = 0;
   int           rsp_count    = 0;
   int           queued_count = 0;
   int unsigned  cycle_count  = 0;
   int           gap_left     = 0;
   int           stall_left   = 0;
   bit           calm         = 1'b0;

   // shadow copy of the screen, cursor and fill attribute
   logic [CHAR_W-1:0] shadow_char  [CELLS];
   logic [CHAR_W-1:0] shadow_color [CELLS];
   int unsigned       shadow_col;
   int unsigned       shadow_row;
   logic [CHAR_W-1:0] shadow_fill;

   text_console_writer u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cursor_col      (rsp_cursor_col),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_char       (rsp_cell_char),
      .rsp_cell_color      (rsp_cell_color),
      .rsp_scrolled        (rsp_scrolled),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   // ---------------------------------------------------------------
   // shadow screen
   // ---------------------------------------------------------------

   // move every row up by one, blank the bottom row in the fill attribute
   function automatic void shadow_scroll();
      for (int i = 0; i < CELLS - COLUMNS; i++) begin
         shadow_char[i]  = shadow_char[i + COLUMNS];
         shadow_color[i] = shadow_color[i + COLUMNS];
      end
      for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
         shadow_char[i]  = CH_BLANK;
         shadow_color[i] = shadow_fill;
      end
      shadow_row = ROWS - 1;
   endfunction

   // wrap past the last column, scroll past the last row
   function automatic bit shadow_settle();
      if (shadow_col >= COLUMNS) begin
         shadow_col = 0;
         shadow_row++;
      end
      if (shadow_row >= ROWS) begin
         shadow_scroll();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // glyph goes in at the cursor, its attribute stays as it was
   function automatic bit shadow_glyph(input logic [CHAR_W-1:0] code);
      shadow_char[shadow_row * COLUMNS + shadow_col] = code;
      shadow_col++;
      return shadow_settle();
   endfunction

   // apply one request to the shadow screen and build the response it owes
   function automatic rsp_type console_step(input console_req_type r);
      rsp_type res;
      bit      sc;
      res = '0;
      sc  = 1'b0;
      case (r.op)
         OP_PUT: begin
            case (r.code)
               CH_NEWLINE: begin
                  shadow_col = 0;
                  shadow_row++;
                  sc = shadow_settle();
               end
               CH_RETURN: begin
                  shadow_col = 0;
               end
               CH_TAB: begin
                  // at least one space, stop on a tab stop or on a wrap
                  for (int n = 0; n < TAB_STOP; n++) begin
                     sc |= shadow_glyph(CH_SPACE);
                     if (shadow_col % TAB_STOP == 0) break;
                  end
               end
               default: begin
                  sc = shadow_glyph(r.code);
               end
            endcase
         end
         OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++) begin
               shadow_char[i]  = CH_BLANK;
               shadow_color[i] = shadow_fill;
            end
            shadow_col = 0;
            shadow_row = 0;
         end
         OP_READ: begin
            // out-of-range reads come back as zero
            if (r.index < CELLS) begin
               res.cell_char  = shadow_char[r.index];
               res.cell_color = shadow_color[r.index];
            end
         end
         default: begin
         end
      endcase
      res.cursor_col      = OUT_COL_W'(shadow_col);
      res.cursor_row      = OUT_ROW_W'(shadow_row);
      res.cursor_position = OUT_POS_W'(shadow_row * COLUMNS + shadow_col);
      res.scrolled        = sc;
      return res;
   endfunction

   initial begin
      for (int i = 0; i < CELLS; i++) begin
         shadow_char[i]  = CH_BLANK;
         shadow_color[i] = RESET_COLOR;
      end
      shadow_col  = 0;
      shadow_row  = 0;
      shadow_fill = RESET_COLOR;
   end

   // ---------------------------------------------------------------
   // helpers for the stimulus process
   // ---------------------------------------------------------------

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   task automatic post_req(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] code,
                           input logic [INDEX_W-1:0] index);
      console_req_type r;
      r.op    = op;
      r.code  = code;
      r.index = index;
      req_pending_q.push_back(r);
      queued_count++;
   endtask

   // hold off until every queued request has its response back
   task automatic wait_drained();
      while (rsp_count < queued_count)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      console_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         // request taken at this edge: predict its response now
         if (req_valid && req_ready) begin
            nxt.op    = req_operation;
            nxt.code  = req_char_code;
            nxt.index = req_cell_index;
            rsp_expected_q.push_back(console_step(nxt));
         end
         // a request still waiting for ready is held untouched
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (req_pending_q.size() != 0) begin
               if (!calm && $urandom_range(0, 9) == 0) begin
                  // idle burst, its length drawn at random
                  gap_left  <= $urandom_range(0, 15);
                  req_valid <= 1'b0;
               end else begin
                  nxt            = req_pending_q.pop_front();
                  req_valid      <= 1'b1;
                  req_operation  <= nxt.op;
                  req_char_code  <= nxt.code;
                  req_cell_index <= nxt.index;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // response monitor and ready generator
   // ---------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.cursor_col      = rsp_cursor_col;
            got.cursor_row      = rsp_cursor_row;
            got.cursor_position = rsp_cursor_position;
            got.cell_char       = rsp_cell_char;
            got.cell_color      = rsp_cell_color;
            got.scrolled        = rsp_scrolled;
            if (rsp_expected_q.size() == 0) begin
               note_failure($sformatf("response %0d arrived with nothing outstanding",
                                      rsp_count));
            end else begin
               want = rsp_expected_q.pop_front();
               if (got !== want)
                  note_failure($sformatf({"response %0d mismatch: expected col %0d row %0d ",
                     "pos %0d char %h color %h scrolled %0b, got col %0d row %0d pos %0d ",
                     "char %h color %h scrolled %0b"}, rsp_count,
                     want.cursor_col, want.cursor_row, want.cursor_position,
                     want.cell_char, want.cell_color, want.scrolled,
                     got.cursor_col, got.cursor_row, got.cursor_position,
                     got.cell_char, got.cell_color, got.scrolled));
            end
            rsp_count++;
         end
         // stall bursts of random length, none once calm
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 15);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // watchdog
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   initial begin : stimulus
      int                kind;
      int                len;
      int                k;
      int                phase_target;
      logic [CHAR_W-1:0] c;
      logic [CHAR_W-1:0] fill;
      logic [INDEX_W-1:0] idx;

      // single reset pulse
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed opening at the reset fill attribute
      post_req(OP_PUT, 8'h41, '0);                 // plain glyph
      post_req(OP_PUT, 8'h00, '1);                 // zero is stored as a glyph
      post_req(OP_PUT, 8'hFF, '0);                 // top code
      post_req(OP_PUT, CH_TAB, '0);                // one space reaches the stop
      post_req(OP_PUT, CH_TAB, '1);                // full run of four spaces
      post_req(OP_READ, '0, INDEX_W'(0));
      post_req(OP_READ, '0, INDEX_W'(3));
      post_req(OP_PUT, CH_RETURN, '0);             // back to column 0
      post_req(OP_PUT, CH_NEWLINE, '0);            // next row
      post_req(OP_READ, '0, INDEX_W'(CELLS - 1));  // last cell
      post_req(OP_READ, '0, INDEX_W'(CELLS));      // first index past the screen
      post_req(OP_READ, 8'hFF, '1);                // top index
      post_req(OP_UNUSED, 8'hFF, '1);              // undecoded opcode
      post_req(OP_CLEAR, 8'h55, INDEX_W'(1234));
      post_req(OP_READ, '0, INDEX_W'(0));
      post_req(OP_PUT, 8'h7E, '0);
      post_req(OP_READ, '0, INDEX_W'(1));

      for (int p = 0; p < PHASES; p++) begin
         // fill attribute only changes with the block drained
         wait_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
         case (p)
            0:       fill = 8'h00;
            1:       fill = 8'hFF;
            2:       fill = 8'h0F;
            3:       fill = CHAR_W'($urandom_range(0, 255));
            4:       fill = 8'h0E;
            default: fill = RESET_COLOR;
         endcase
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_wdata <= fill;
         shadow_fill = fill;
         @(posedge clock);
         csr_we <= 1'b0;

         // last phase runs with no idling on either side
         calm = (p == PHASES - 1);

         // start each phase on a blank screen in the new attribute
         post_req(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
                  INDEX_W'($urandom_range(0, 2047)));

         phase_target = queued_count + REQS_PER_PHASE;
         while (queued_count < phase_target) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
               // a line of text, mostly printable, tabs mixed in
               k = $urandom_range(0, 99);
               if (k < 50)      len = $urandom_range(0, 8);
               else if (k < 85) len = $urandom_range(9, 40);
               else             len = $urandom_range(41, 120);
               for (int i = 0; i < len; i++) begin
                  k = $urandom_range(0, 99);
                  if (k < 8)       c = CH_TAB;
                  else if (k < 80) c = CHAR_W'($urandom_range(8'h20, 8'h7E));
                  else             c = CHAR_W'($urandom_range(0, 255));
                  post_req(OP_PUT, c, INDEX_W'($urandom_range(0, 2047)));
               end
               k = $urandom_range(0, 9);
               if (k < 8)      post_req(OP_PUT, CH_NEWLINE, INDEX_W'($urandom_range(0, 2047)));
               else if (k < 9) post_req(OP_PUT, CH_RETURN, INDEX_W'($urandom_range(0, 2047)));
            end else if (kind < 78) begin
               // run of newlines pushes the cursor down and scrolls once it passes the bottom
               len = $urandom_range(1, 16);
               for (int i = 0; i < len; i++)
                  post_req(OP_PUT, CH_NEWLINE, INDEX_W'($urandom_range(0, 2047)));
            end else if (kind < 92) begin
               // reads, leaning on the bottom row where scrolls refill
               len = $urandom_range(1, 4);
               for (int i = 0; i < len; i++) begin
                  k = $urandom_range(0, 9);
                  if (k == 0)     idx = INDEX_W'($urandom_range(CELLS, 2047));
                  else if (k < 4) idx = INDEX_W'($urandom_range(CELLS - COLUMNS, CELLS - 1));
                  else            idx = INDEX_W'($urandom_range(0, CELLS - 1));
                  post_req(OP_READ, CHAR_W'($urandom_range(0, 255)), idx);
               end
            end else if (kind < 95) begin
               post_req(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
                        INDEX_W'($urandom_range(0, 2047)));
            end else if (kind < 98) begin
               post_req(OP_UNUSED, CHAR_W'($urandom_range(0, 255)),
                        INDEX_W'($urandom_range(0, 2047)));
            end else begin
               // noise: any opcode, any fields
               post_req(OP_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                        INDEX_W'($urandom_range(0, 2047)));
            end
         end
      end

      // drain, then give the block time to show any stray response
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (rsp_expected_q.size() != 0)
         note_failure($sformatf("%0d responses never arrived", rsp_expected_q.size()));
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: text_console_writer.f
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_sequencer.sv
sv/text_console_writer.sv
dv/tb_text_console_writer.sv
